/* rtl/string_hash_city_djb2_macros.svh */
// Assertion helpers shared by the string hash RTL.
// Each macro expects signals named clk and rst in the enclosing module.
`ifndef STRING_HASH_CITY_DJB2_MACROS_SVH
`define STRING_HASH_CITY_DJB2_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SHCD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SHCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/shcd_pkg.sv */
// ----------------------------------------------------------------------------
// shcd_pkg
// Shared types and constants of the string hash block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package shcd_pkg;

  // Length counter width; covers a saturation value of up to 63.
  localparam int LEN_W = 6;

  localparam logic [63:0] DJB2_INIT  = 64'd5381;
  localparam logic [63:0] MIX_ADD    = 64'h0000_0000_52dc_e729;
  localparam logic [31:0] MIX_MUL_LO = 32'heb38_2d69;
  localparam logic [31:0] MIX_MUL_HI = 32'h9ddf_ea08;
  localparam logic [63:0] SHORT_C    = 64'd9;
  localparam logic [LEN_W-1:0] HEAD_BYTES = LEN_W'(16);

  // One finished string as handed from the front end to the mixer.
  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [127:0]     head;
    logic [127:0]     tail;
    logic [63:0]      djb2;
  } shcd_entry_t;

endpackage

`default_nettype wire

/* rtl/shcd_front.sv */
// ----------------------------------------------------------------------------
// shcd_front
// Byte absorber: collects head bytes, the tail window, the djb2 sum and the
// saturating length, and hands a snapshot to the queue on the last byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module shcd_front #(
  parameter int LONG_THRESHOLD = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [7:0]           byte_in,
  input  wire logic                 last_byte,
  input  wire logic                 empty_string,
  input  wire logic                 q_full,
  output logic                      push,
  output shcd_pkg::shcd_entry_t     push_entry
);
  import shcd_pkg::*;

  localparam logic [LEN_W-1:0] LEN_SAT = LEN_W'(LONG_THRESHOLD + 1);

  logic [127:0]     head, head_next;
  logic [127:0]     tail, tail_next;
  logic [63:0]      djb2, djb2_next;
  logic [LEN_W-1:0] len, len_next;
  logic             accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    head_next = head;
    tail_next = tail;
    djb2_next = djb2;
    len_next  = len;
    if (!empty_string) begin
      if (len < HEAD_BYTES) begin
        head_next[{len[3:0], 3'b000} +: 8] = byte_in;
      end
      tail_next = {byte_in, tail[127:8]};
      djb2_next = (djb2 << 5) + djb2 + {56'd0, byte_in};
      if (len < LEN_SAT) begin
        len_next = len + LEN_W'(1);
      end
    end
  end

  assign push            = accept && last_byte;
  assign push_entry.len  = len_next;
  assign push_entry.head = head_next;
  assign push_entry.tail = tail_next;
  assign push_entry.djb2 = djb2_next;

  always_ff @(posedge clk) begin
    if (rst || push) begin
      head <= '0;
      tail <= '0;
      djb2 <= DJB2_INIT;
      len  <= '0;
    end else if (accept) begin
      head <= head_next;
      tail <= tail_next;
      djb2 <= djb2_next;
      len  <= len_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/shcd_queue.sv */
// ----------------------------------------------------------------------------
// shcd_queue
// Two-entry queue of finished strings between the absorber and the mixer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "string_hash_city_djb2_macros.svh"

module shcd_queue (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire shcd_pkg::shcd_entry_t push_entry,
  output logic                       full,
  output logic                       not_empty,
  input  wire logic                  pop,
  output shcd_pkg::shcd_entry_t      head_entry
);
  import shcd_pkg::*;

  shcd_entry_t entries [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign full       = (count == 2'd2);
  assign not_empty  = (count != 2'd0);
  assign head_entry = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  `SHCD_ASSERT_NOW(a_no_push_full, push, !full, "push into a full string queue")
  `SHCD_ASSERT_NOW(a_no_pop_empty, pop, not_empty, "pop from an empty string queue")
  `SHCD_ASSERT_NOW(a_count_range, 1'b1, count <= 2'd2, "string queue count out of range")

endmodule

`default_nettype wire

/* rtl/shcd_mix.sv */
// ----------------------------------------------------------------------------
// shcd_mix
// Final hash sequencer: djb2 pass-through for long strings, otherwise the
// City-style mix with the 64-bit multiply done on one 32x32 multiplier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "string_hash_city_djb2_macros.svh"

module shcd_mix #(
  parameter int LONG_THRESHOLD = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  q_not_empty,
  input  wire shcd_pkg::shcd_entry_t q_entry,
  output logic                       pop,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [63:0]                hash_value
);
  import shcd_pkg::*;

  localparam logic [LEN_W-1:0] LEN_LONG = LEN_W'(LONG_THRESHOLD);

  typedef enum logic [3:0] {
    ST_IDLE, ST_MIX_A, ST_MIX_D, ST_MUL0, ST_MUL1, ST_MUL2, ST_MUL3, ST_OUT
  } state_t;

  state_t      state;
  logic [63:0] a_reg;
  logic [63:0] b_reg;
  logic [63:0] d_reg;
  logic [63:0] acc;
  logic [63:0] prod;

  logic [63:0] sel_a, sel_b, sel_c, sel_d, ab_sum, a_first, a_scaled, dx;
  logic [31:0] mul_x, mul_y;
  logic [63:0] mul_p;

  // Word selection follows the short and medium string layouts.
  always_comb begin
    sel_a = q_entry.head[63:0];
    if (q_entry.len <= HEAD_BYTES) begin
      sel_b = q_entry.tail[127:64];
      sel_c = SHORT_C;
      sel_d = 64'({q_entry.len, 2'b00}) + 64'(q_entry.len);
    end else begin
      sel_b = q_entry.head[127:64];
      sel_c = q_entry.tail[127:64];
      sel_d = q_entry.tail[63:0];
    end
    ab_sum   = sel_a + sel_b;
    a_first  = {ab_sum[20:0], ab_sum[63:21]} + sel_c;
    a_scaled = (a_reg << 2) + a_reg + MIX_ADD;
    dx       = d_reg ^ a_reg;
  end

  // Shared multiplier: low by low, then the two cross terms.
  always_comb begin
    unique case (state)
      ST_MUL1: begin
        mul_x = d_reg[31:0];
        mul_y = MIX_MUL_HI;
      end
      ST_MUL2: begin
        mul_x = d_reg[63:32];
        mul_y = MIX_MUL_LO;
      end
      default: begin
        mul_x = d_reg[31:0];
        mul_y = MIX_MUL_LO;
      end
    endcase
    mul_p = 64'(mul_x) * 64'(mul_y);
  end

  assign pop       = (state == ST_IDLE) && q_not_empty;
  assign out_valid = (state == ST_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (q_not_empty) begin
            if (q_entry.len > LEN_LONG) begin
              hash_value <= q_entry.djb2;
              state      <= ST_OUT;
            end else begin
              a_reg <= a_first;
              b_reg <= sel_b;
              d_reg <= sel_d;
              state <= ST_MIX_A;
            end
          end
        end
        ST_MIX_A: begin
          a_reg <= a_scaled;
          state <= ST_MIX_D;
        end
        ST_MIX_D: begin
          d_reg <= {dx[19:0], dx[63:20]} + b_reg;
          state <= ST_MUL0;
        end
        ST_MUL0: begin
          prod  <= mul_p;
          state <= ST_MUL1;
        end
        ST_MUL1: begin
          acc   <= prod;
          prod  <= mul_p;
          state <= ST_MUL2;
        end
        ST_MUL2: begin
          acc   <= acc + {prod[31:0], 32'd0};
          prod  <= mul_p;
          state <= ST_MUL3;
        end
        ST_MUL3: begin
          hash_value <= acc + {prod[31:0], 32'd0};
          state      <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_stall) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `SHCD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(hash_value), "result dropped while stalled")
  `SHCD_ASSERT_NOW(a_pop_idle, pop, !out_valid, "string taken while a result is pending")

endmodule

`default_nettype wire

/* rtl/string_hash_city_djb2.sv */
// ----------------------------------------------------------------------------
// string_hash_city_djb2
// Streaming string hash: City-style mix for short strings, djb2 for long ones.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle; a request with last_byte set closes the
// string, and empty_string marks a request that carries no byte. Each closed
// string yields one 64-bit hash_value. The absorber stalls only while the
// two-entry queue of closed strings is full, and when results back up this
// can happen in the middle of a string.
// The mixer passes the djb2 sum through for strings above LONG_THRESHOLD
// bytes and otherwise runs three mix steps and a 64-bit multiply on one
// 32x32 multiplier in states ST_MUL0 to ST_MUL3; it holds a result while
// out_stall is high and takes the next string only once that result is gone.
`timescale 1ns / 1ps
`default_nettype none

module string_hash_city_djb2 #(
  parameter int LONG_THRESHOLD = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  byte_in,
  input  wire logic        last_byte,
  input  wire logic        empty_string,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      hash_value
);
  import shcd_pkg::*;

  logic        q_full;
  logic        q_not_empty;
  logic        push;
  logic        pop;
  shcd_entry_t push_entry;
  shcd_entry_t q_entry;

  shcd_front #(
    .LONG_THRESHOLD (LONG_THRESHOLD)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .byte_in      (byte_in),
    .last_byte    (last_byte),
    .empty_string (empty_string),
    .q_full       (q_full),
    .push         (push),
    .push_entry   (push_entry)
  );

  shcd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .not_empty  (q_not_empty),
    .pop        (pop),
    .head_entry (q_entry)
  );

  shcd_mix #(
    .LONG_THRESHOLD (LONG_THRESHOLD)
  ) u_mix (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_entry     (q_entry),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .hash_value  (hash_value)
  );

endmodule

`default_nettype wire
